// ===== sv/prpu_pkg.sv =====
`timescale 1ns / 1ps

package prpu_pkg;

    // Widths of the transaction fields on the ports.
    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 2;
    localparam int FAULT_W       = 32;

    // Replacement mode held in the configuration register.
    typedef enum logic [0:0] {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

endpackage

// ===== sv/page_replacement_policy_unit.sv =====
// An accepted transaction passes through the input register and then the result register
// before its result shows on the result channel.
// Throughput: one page reference per cycle while out_stall is low; the tag compare, victim
// choice and rank update happen combinationally between the input and result registers.
// Reset (asynchronous, active low) empties all frames, zeroes ranks, pointer and fault
// count and selects FIFO mode; no clearing pass is needed, so the block is ready at once.
`timescale 1ns / 1ps

module page_replacement_policy_unit #(
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port for the replacement mode register.
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    // Page reference channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [prpu_pkg::PAGE_NUMBER_W-1:0]  page_number,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [prpu_pkg::FRAME_INDEX_W-1:0]  frame_index,
    output logic                                evicted_valid,
    output logic [prpu_pkg::PAGE_NUMBER_W-1:0]  evicted_page,
    output logic [prpu_pkg::FAULT_W-1:0]        fault_total
);

    import prpu_pkg::*;

    // Only the low PAGE_BITS bits of a page number matter, and the port carries at most
    // PAGE_NUMBER_W of them, so the frame tags are as wide as the smaller of the two.
    localparam int TAG_BITS = (PAGE_BITS < PAGE_NUMBER_W) ? PAGE_BITS : PAGE_NUMBER_W;
    localparam int IDX_W    = $clog2(FRAME_COUNT);
    localparam int RANK_W   = $clog2(FRAME_COUNT);

    localparam logic [IDX_W-1:0]  LAST_FRAME = IDX_W'(FRAME_COUNT - 1);
    localparam logic [RANK_W-1:0] OLDEST     = RANK_W'(FRAME_COUNT - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    policy_t                   policy_reg;

    // Input stage: holds one accepted reference until it is processed.
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [TAG_BITS-1:0]       s1_page_reg;

    // Frame table. Tags are payload and are only read while the frame is valid.
    logic [TAG_BITS-1:0]       frame_page_reg  [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]    frame_valid_reg;
    logic [FRAME_COUNT-1:0]    frame_valid_next;
    logic [RANK_W-1:0]         rank_reg        [FRAME_COUNT];
    logic [RANK_W-1:0]         rank_next       [FRAME_COUNT];
    logic [IDX_W-1:0]          fifo_ptr_reg;
    logic [IDX_W-1:0]          fifo_ptr_next;
    logic [FAULT_W-1:0]        fault_cnt_reg;
    logic [FAULT_W-1:0]        fault_cnt_next;

    // Result stage.
    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    logic                      hit_reg;
    logic [FRAME_INDEX_W-1:0]  frame_index_reg;
    logic                      evicted_valid_reg;
    logic [PAGE_NUMBER_W-1:0]  evicted_page_reg;

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic in_accept;
    logic advance;

    // The input stage moves on whenever the result register is empty or being drained,
    // which keeps a full pipeline running at one transaction per cycle.
    assign advance   = s1_valid_reg && !(s2_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next = in_accept || (s1_valid_reg && !advance);
    assign s2_valid_next = advance || (s2_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Lookup and victim selection
    // ------------------------------------------------------------------
    logic [FRAME_COUNT-1:0] match_vec;
    logic [FRAME_COUNT-1:0] oldest_vec;
    logic                   found;
    logic [IDX_W-1:0]       match_idx;
    logic                   has_empty;
    logic [IDX_W-1:0]       empty_idx;
    logic [IDX_W-1:0]       oldest_idx;
    logic [IDX_W-1:0]       used_idx;
    logic                   evict;
    logic [TAG_BITS-1:0]    evict_tag;
    logic                   do_touch;
    logic                   used_was_valid;
    logic [RANK_W-1:0]      used_rank;

    // Lowest-index winners: scanning from the top lets the lower index overwrite.
    always_comb
    begin
        found      = 1'b0;
        match_idx  = '0;
        has_empty  = 1'b0;
        empty_idx  = '0;
        oldest_idx = '0;
        for (int g = FRAME_COUNT - 1; g >= 0; g--)
        begin
            match_vec[g]  = frame_valid_reg[g] && (frame_page_reg[g] == s1_page_reg);
            oldest_vec[g] = (rank_reg[g] == OLDEST);
            if (match_vec[g])
            begin
                found     = 1'b1;
                match_idx = IDX_W'(g);
            end
            if (!frame_valid_reg[g])
            begin
                has_empty = 1'b1;
                empty_idx = IDX_W'(g);
            end
            if (oldest_vec[g])
            begin
                oldest_idx = IDX_W'(g);
            end
        end
    end

    // When every frame is full the ranks form a permutation, so the least recently used
    // frame is simply the one holding the oldest rank.
    always_comb
    begin
        if (found)
        begin
            used_idx = match_idx;
        end
        else if (has_empty)
        begin
            used_idx = empty_idx;
        end
        else if (policy_reg == POLICY_LRU)
        begin
            used_idx = oldest_idx;
        end
        else
        begin
            used_idx = fifo_ptr_reg;
        end
    end

    assign evict          = !found && !has_empty;
    assign evict_tag      = evict ? frame_page_reg[used_idx] : '0;
    assign do_touch       = !found || (policy_reg == POLICY_LRU);
    assign used_was_valid = frame_valid_reg[used_idx];
    assign used_rank      = rank_reg[used_idx];

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    // Touching a frame makes it the most recent and ages every valid frame that was
    // newer than it. A frame that was empty counts as older than all others.
    always_comb
    begin
        for (int g = 0; g < FRAME_COUNT; g++)
        begin
            rank_next[g] = rank_reg[g];
            if (advance && do_touch)
            begin
                if (IDX_W'(g) == used_idx)
                begin
                    rank_next[g] = '0;
                end
                else if (frame_valid_reg[g] && (!used_was_valid || (rank_reg[g] < used_rank))
                         && (rank_reg[g] != OLDEST))
                begin
                    rank_next[g] = rank_reg[g] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        fifo_ptr_next    = fifo_ptr_reg;
        fault_cnt_next   = fault_cnt_reg;
        if (advance && !found)
        begin
            frame_valid_next[used_idx] = 1'b1;
            fifo_ptr_next = (used_idx == LAST_FRAME) ? '0 : IDX_W'(used_idx + 1'b1);
            if (fault_cnt_reg != {FAULT_W{1'b1}})
            begin
                fault_cnt_next = fault_cnt_reg + 1'b1;
            end
        end
    end

    // Control state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= POLICY_FIFO;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            frame_valid_reg <= '0;
            fifo_ptr_reg    <= '0;
            fault_cnt_reg   <= '0;
            for (int g = 0; g < FRAME_COUNT; g++)
            begin
                rank_reg[g] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                policy_reg <= policy_t'(cfg_wr_data);
            end
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            frame_valid_reg <= frame_valid_next;
            fifo_ptr_reg    <= fifo_ptr_next;
            fault_cnt_reg   <= fault_cnt_next;
            for (int g = 0; g < FRAME_COUNT; g++)
            begin
                rank_reg[g] <= rank_next[g];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_page_reg <= page_number[TAG_BITS-1:0];
        end
        if (advance)
        begin
            if (!found)
            begin
                frame_page_reg[used_idx] <= s1_page_reg;
            end
            hit_reg           <= found;
            frame_index_reg   <= FRAME_INDEX_W'(used_idx);
            evicted_valid_reg <= evict;
            evicted_page_reg  <= PAGE_NUMBER_W'(evict_tag);
        end
    end

    assign out_valid     = s2_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_cnt_reg;

`ifndef ASSERT_OFF
    // With all frames full exactly one frame holds the oldest rank.
    a_oldest_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (&frame_valid_reg) |-> $onehot(oldest_vec))
        else $error("oldest rank not unique among full frames");

    // A filled frame never becomes empty again.
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((frame_valid_reg & $past(frame_valid_reg)) == $past(frame_valid_reg)))
        else $error("frame valid bit dropped");

    // A hit evicts nothing and leaves the fault count alone.
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && found) |=> (!evicted_valid_reg && $stable(fault_cnt_reg)))
        else $error("hit changed fault state");

    // A fault below saturation counts exactly once.
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !found && (fault_cnt_reg != {FAULT_W{1'b1}}))
        |=> (fault_cnt_reg == $past(fault_cnt_reg) + 1'b1))
        else $error("fault count not advanced");
`endif

endmodule
